/* rtl/acs_pkg.sv */
// Shared types and constants for the accumulator CPU step core.
// Depends on nothing; imported by acs_div and accumulator_cpu_step_core.
package acs_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned ADDR_W = 12;

    // request kinds
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_EXEC  = 2'd2;

    // opcodes (high nibble of an instruction byte)
    localparam logic [3:0] OP_LOAD  = 4'h0;
    localparam logic [3:0] OP_STORE = 4'h1;
    localparam logic [3:0] OP_MOVE  = 4'h2;
    localparam logic [3:0] OP_GET   = 4'h3;
    localparam logic [3:0] OP_CLEAR = 4'h4;
    localparam logic [3:0] OP_ADD   = 4'h5;
    localparam logic [3:0] OP_NEG   = 4'h6;
    localparam logic [3:0] OP_MUL   = 4'h7;
    localparam logic [3:0] OP_DIV   = 4'h8;
    localparam logic [3:0] OP_GT    = 4'h9;
    localparam logic [3:0] OP_EQ    = 4'hA;
    localparam logic [3:0] OP_JMP   = 4'hB;
    localparam logic [3:0] OP_JC    = 4'hC;
    localparam logic [3:0] OP_HALT  = 4'hD;

    // operand codes
    localparam logic [3:0] OPD_TEMP = 4'd4;
    localparam logic [3:0] OPD_ACC  = 4'd5;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] mem_addr;
        logic [BYTE_W-1:0] mem_data;
    } req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic [BYTE_W-1:0] acc_value;
        logic [BYTE_W-1:0] pc_value;
        logic              flag_value;
        logic              is_halted;
    } rsp_t;

endpackage

/* rtl/acs_div.sv */
// Iterative unsigned byte divider, one quotient bit per cycle (restoring).
// Depends on acs_pkg for the byte width.
module acs_div (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    input  logic [7:0] dividend,
    input  logic [7:0] divisor,
    output logic       done,
    output logic [7:0] quotient
);
    import acs_pkg::*;

    localparam int unsigned CNT_W = $clog2(BYTE_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [BYTE_W-1:0] rem_reg;
    logic [BYTE_W-1:0] quo_reg;
    logic [BYTE_W-1:0] dsr_reg;

    logic [BYTE_W:0]   shifted;
    logic [BYTE_W+1:0] diff;

    always_comb begin
        shifted = {rem_reg, quo_reg[BYTE_W-1]};
        diff    = {1'b0, shifted} - {2'b00, dsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dsr_reg  <= divisor;
            end else if (busy_reg) begin
                // borrow clear: divisor fits, take the difference
                if (!diff[BYTE_W+1]) begin
                    rem_reg <= diff[BYTE_W-1:0];
                end else begin
                    rem_reg <= shifted[BYTE_W-1:0];
                end
                quo_reg <= {quo_reg[BYTE_W-2:0], ~diff[BYTE_W+1]};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(BYTE_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/accumulator_cpu_step_core.sv */
// Accumulator CPU step core: 8-bit accumulator processor with a byte memory.
// One request at a time; reads, loads and stores wait on the registered memory
// read port and divides on the bit-serial divider, while writes, halted
// executes and unknown kinds go straight to publishing the result.
// Reset: synchronous active-low aresetn clears the control registers, then a pass
// zeroes all MEM_DEPTH (4096) words; no request is taken until it ends.
// Depends on acs_pkg and acs_div.
module accumulator_cpu_step_core #(
    parameter int unsigned MEM_DEPTH = 4096
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  acs_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output acs_pkg::rsp_t m_data
);
    import acs_pkg::*;

    localparam int unsigned AW = $clog2(MEM_DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR,   // zeroing memory after reset
        ST_IDLE,    // waiting for a request
        ST_RD,      // read data for a memory read request arrives
        ST_FETCH,   // instruction byte arrives; decode and execute most ops
        ST_OPER,    // low address byte of load/store arrives
        ST_LOAD,    // load data arrives
        ST_DIV,     // waiting on the divider
        ST_DONE     // publish the result
    } state_t;

    state_t            state_reg;
    logic [AW-1:0]     clr_cnt_reg;

    logic [BYTE_W-1:0] mem [MEM_DEPTH];
    logic [BYTE_W-1:0] mem_rdata_reg;

    logic [BYTE_W-1:0] gp_reg [4];
    logic [BYTE_W-1:0] temp_reg;
    logic [BYTE_W-1:0] acc_reg;
    logic [BYTE_W-1:0] pc_reg;
    logic              flag_reg;
    logic              halt_reg;
    logic [3:0]        opd_reg;
    logic              is_store_reg;
    logic [BYTE_W-1:0] rd_reg;

    logic              m_valid_reg;
    rsp_t              m_data_reg;

    // memory port control
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;

    // decode of the fetched instruction
    logic [3:0]        op;
    logic [3:0]        opd;
    logic              src_ok;
    logic [BYTE_W-1:0] src_val;
    logic [BYTE_W-1:0] pc_inc;
    logic [2*BYTE_W-1:0] product;
    logic [AW-1:0]     ls_addr;

    logic              s_fire;
    logic              div_start;
    logic              div_done;
    logic [BYTE_W-1:0] div_quo;

    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        op      = mem_rdata_reg[7:4];
        opd     = mem_rdata_reg[3:0];
        src_ok  = 1'b0;
        src_val = '0;
        if (opd < OPD_TEMP) begin
            src_ok  = 1'b1;
            src_val = gp_reg[opd[1:0]];
        end else if (opd == OPD_TEMP) begin
            src_ok  = 1'b1;
            src_val = temp_reg;
        end
        pc_inc    = pc_reg + 1'b1;
        product   = acc_reg * src_val;
        // load/store address: operand nibble over the second byte
        ls_addr   = AW'({opd_reg, mem_rdata_reg});
        div_start = (state_reg == ST_FETCH) && (op == OP_DIV) && src_ok
                    && (src_val != '0);
    end

    // memory port: one write and one registered read per cycle
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = '0;
        mem_raddr = AW'(pc_reg);
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_IDLE: begin
                mem_we    = s_fire && (s_data.req_type == REQ_WRITE);
                mem_waddr = AW'(s_data.mem_addr);
                mem_wdata = s_data.mem_data;
                if (s_data.req_type == REQ_READ) begin
                    mem_raddr = AW'(s_data.mem_addr);
                end
            end
            ST_FETCH: begin
                mem_raddr = AW'(pc_inc);  // second byte of load/store
            end
            ST_OPER: begin
                mem_we    = is_store_reg;
                mem_waddr = ls_addr;
                mem_wdata = acc_reg;
                mem_raddr = ls_addr;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    acs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (src_val),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
            gp_reg[0]    <= '0;
            gp_reg[1]    <= '0;
            gp_reg[2]    <= '0;
            gp_reg[3]    <= '0;
            temp_reg     <= '0;
            acc_reg      <= '0;
            pc_reg       <= '0;
            flag_reg     <= 1'b0;
            halt_reg     <= 1'b0;
            is_store_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(MEM_DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_fire) begin
                        rd_reg <= '0;
                        priority if (s_data.req_type == REQ_READ) begin
                            state_reg <= ST_RD;
                        end else if (s_data.req_type == REQ_EXEC && !halt_reg) begin
                            state_reg <= ST_FETCH;
                        end else begin
                            // write, halted execute, or unknown kind
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_RD: begin
                    rd_reg    <= mem_rdata_reg;
                    state_reg <= ST_DONE;
                end
                ST_FETCH: begin
                    pc_reg       <= pc_inc;
                    opd_reg      <= opd;
                    is_store_reg <= (op == OP_STORE);
                    state_reg    <= ST_DONE;
                    unique case (op)
                        OP_LOAD, OP_STORE: begin
                            state_reg <= ST_OPER;
                        end
                        OP_MOVE: begin
                            if (opd < OPD_TEMP) begin
                                gp_reg[opd[1:0]] <= acc_reg;
                            end else if (opd == OPD_TEMP) begin
                                temp_reg <= acc_reg;
                            end
                        end
                        OP_GET: begin
                            if (src_ok) begin
                                acc_reg <= src_val;
                            end
                        end
                        OP_CLEAR: begin
                            if (opd < OPD_TEMP) begin
                                gp_reg[opd[1:0]] <= '0;
                            end else if (opd == OPD_TEMP) begin
                                temp_reg <= '0;
                            end else if (opd == OPD_ACC) begin
                                acc_reg <= '0;
                            end
                        end
                        OP_ADD: begin
                            if (opd < OPD_TEMP) begin
                                acc_reg <= acc_reg + src_val;
                            end
                        end
                        OP_NEG: begin
                            acc_reg <= '0 - acc_reg;
                        end
                        OP_MUL: begin
                            if (src_ok) begin
                                acc_reg <= product[BYTE_W-1:0];
                            end
                        end
                        OP_DIV: begin
                            if (div_start) begin
                                state_reg <= ST_DIV;
                            end
                        end
                        OP_GT: begin
                            if (src_ok) begin
                                flag_reg <= (acc_reg > src_val);
                            end
                        end
                        OP_EQ: begin
                            if (src_ok) begin
                                flag_reg <= (acc_reg == src_val);
                            end
                        end
                        OP_JMP: begin
                            pc_reg <= pc_inc + BYTE_W'(opd);
                        end
                        OP_JC: begin
                            if (flag_reg) begin
                                pc_reg <= pc_inc + BYTE_W'(opd);
                            end
                        end
                        OP_HALT: begin
                            halt_reg <= 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                ST_OPER: begin
                    // second byte consumed; store writes this cycle
                    pc_reg <= pc_reg + 1'b1;
                    if (is_store_reg) begin
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    acc_reg   <= mem_rdata_reg;
                    state_reg <= ST_DONE;
                end
                ST_DIV: begin
                    if (div_done) begin
                        acc_reg   <= div_quo;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    m_valid_reg           <= 1'b1;
                    m_data_reg.read_byte  <= rd_reg;
                    m_data_reg.acc_value  <= acc_reg;
                    m_data_reg.pc_value   <= pc_reg;
                    m_data_reg.flag_value <= flag_reg;
                    m_data_reg.is_halted  <= halt_reg;
                    state_reg             <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
